/* sv/btp_pkg.sv */
package btp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;
    localparam int MIN_DIM    = 3;
    localparam int LINE_AW    = $clog2(MAX_WIDTH);
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW    = FIFO_AW + 1;
    localparam int TDATA_W    = ((PIX_W + COORD_W + ROW_W + 7) / 8) * 8;

    localparam logic [PIX_W-1:0] PIX_ONE  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] col;
        logic [ROW_W-1:0]   row;
        logic               last;
        logic               changed;
    } t_res;

    typedef struct packed {
        logic               valid;
        logic [PIX_W-1:0]   px;
        logic [COORD_W-1:0] col;
        logic [ROW_W-1:0]   row;
        logic               interior;
        logic               border;
        logic               last;
        logic               frame_end;
    } t_s1;

endpackage

/* sv/btp_line_store.sv */
module btp_line_store
    import btp_pkg::*;
(
    input  logic               i_clk,
    input  logic [LINE_AW-1:0] i_rd_addr,
    input  logic               i_wr_en,
    input  logic [LINE_AW-1:0] i_wr_addr,
    input  logic [PIX_W-1:0]   i_wr_mid,
    input  logic [PIX_W-1:0]   i_wr_top,
    output logic [PIX_W-1:0]   o_mid,
    output logic [PIX_W-1:0]   o_top
);

    // mid row holds row r-1, top row holds row r-2
    logic [PIX_W-1:0] r_mem_mid [MAX_WIDTH];
    logic [PIX_W-1:0] r_mem_top [MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_mid[i_wr_addr] <= i_wr_mid;
            r_mem_top[i_wr_addr] <= i_wr_top;
        end
    end

    always_ff @(posedge i_clk) begin
        o_mid <= r_mem_mid[i_rd_addr];
        o_top <= r_mem_top[i_rd_addr];
    end

endmodule

/* sv/btp_window.sv */
module btp_window
    import btp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [PIX_W-1:0] i_top,
    input  logic [PIX_W-1:0] i_mid,
    input  logic [PIX_W-1:0] i_px,
    output logic [PIX_W-1:0] o_center,
    output logic             o_removable
);

    // templates, bit index y*3+x, care = entry is not don't-care
    localparam logic [8:0] T0_CARE = 9'b111010111;
    localparam logic [8:0] T0_ONE  = 9'b111010000;
    localparam logic [8:0] T1_CARE = 9'b010111110;
    localparam logic [8:0] T1_ONE  = 9'b010011000;
    localparam logic [3:0] MIN_ONES = 4'd3;

    logic [PIX_W-1:0] r_win [3][3];
    logic [PIX_W-1:0] n_win [3][3];
    logic [8:0]       is_one;
    logic [8:0]       is_zero;
    logic [3:0]       ones;
    logic             hit;

    always_comb begin
        for (int y = 0; y < 3; y++) begin
            n_win[y][0] = r_win[y][1];
            n_win[y][1] = r_win[y][2];
        end
        n_win[0][2] = i_top;
        n_win[1][2] = i_mid;
        n_win[2][2] = i_px;
    end

    always_comb begin
        for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 3; x++) begin
                is_one[y*3+x]  = (n_win[y][x] == PIX_ONE);
                is_zero[y*3+x] = (n_win[y][x] == PIX_ZERO);
            end
        end
        ones = 4'($countones(is_one));
    end

    always_comb begin
        logic ok;
        int   ty;
        int   tx;
        int   ti;
        hit = 1'b0;
        for (int rot = 0; rot < 4; rot++) begin
            for (int t = 0; t < 2; t++) begin
                ok = 1'b1;
                for (int y = 0; y < 3; y++) begin
                    for (int x = 0; x < 3; x++) begin
                        unique case (rot)
                            1: begin ty = x;     tx = 2 - y; end
                            2: begin ty = 2 - y; tx = 2 - x; end
                            3: begin ty = 2 - x; tx = y;     end
                            default: begin ty = y; tx = x; end
                        endcase
                        ti = ty * 3 + tx;
                        if (t == 0) begin
                            if (T0_CARE[ti])
                                ok = ok & (T0_ONE[ti] ? is_one[y*3+x] : is_zero[y*3+x]);
                        end else begin
                            if (T1_CARE[ti])
                                ok = ok & (T1_ONE[ti] ? is_one[y*3+x] : is_zero[y*3+x]);
                        end
                    end
                end
                hit = hit | ok;
            end
        end
    end

    assign o_center    = n_win[1][1];
    assign o_removable = (n_win[1][1] != PIX_ZERO) && (ones >= MIN_ONES) && hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int y = 0; y < 3; y++)
                for (int x = 0; x < 3; x++)
                    r_win[y][x] <= PIX_ZERO;
        end else if (i_shift) begin
            r_win <= n_win;
        end
    end

endmodule

/* sv/btp_out_fifo.sv */
module btp_out_fifo
    import btp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_wr_cnt,
    input  t_res               i_wr_a,
    input  t_res               i_wr_b,
    output logic               o_valid,
    input  logic               i_ready,
    output t_res               o_data,
    output logic [FIFO_LW-1:0] o_level
);

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_LW-1:0] r_level;
    logic [FIFO_AW-1:0] n_wp;
    logic [FIFO_AW-1:0] n_rp;
    logic [FIFO_LW-1:0] n_level;
    logic               pop;

    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rp];
    assign o_level = r_level;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wp    = r_wp + FIFO_AW'(i_wr_cnt);
        n_rp    = r_rp + FIFO_AW'(pop);
        n_level = r_level + FIFO_LW'(i_wr_cnt) - FIFO_LW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0)
            r_mem[r_wp] <= i_wr_a;
        if (i_wr_cnt == 2'd2)
            r_mem[r_wp + FIFO_AW'(1)] <= i_wr_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_level <= n_level;
        end
    end

endmodule

/* sv/binary_thinning_pass_3x3.sv */
// Path: a result reaches m_axis through the stage 1 register and the output queue once the item that completes it
//   is taken (border pixels: their own item; interior pixels: the item one row and one column later).
// Throughput: one item per cycle; items giving two results (right column, bottom row)
//   drain at one result per cycle through an 8-entry output queue that sets s_axis_tready.
// Reset: i_rst_n synchronous, active low; clears counters, window, removed flag and queue,
//   sets both dimensions to 1024. Line store contents are not cleared.
module binary_thinning_pass_3x3
    import btp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [PIX_W-1:0]   s_axis_tdata,   // [7:0] pixel
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [7:0] out_pixel, [17:8] out_col, [27:18] out_row
    output logic               m_axis_tlast,   // last_of_frame
    output logic               m_axis_tuser,   // frame_changed
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [DIM_W-1:0]   i_cfg_data
);

    logic [DIM_W-1:0]   r_cfg_w;
    logic [DIM_W-1:0]   r_cfg_h;
    logic [COORD_W-1:0] r_col;
    logic [ROW_W-1:0]   r_row;
    logic               r_flag;
    t_s1                r_s1;

    logic [COORD_W-1:0] n_col;
    logic [ROW_W-1:0]   n_row;
    logic               n_flag;
    t_s1                n_s1;

    logic [DIM_W-1:0]   w_use;
    logic [DIM_W-1:0]   h_use;
    logic [DIM_W-1:0]   col_inc;
    logic [DIM_W-1:0]   row_inc;
    logic [DIM_W-1:0]   col_x;
    logic [DIM_W-1:0]   row_x;
    logic               accept;

    logic [PIX_W-1:0]   mem_mid;
    logic [PIX_W-1:0]   mem_top;
    logic [PIX_W-1:0]   center;
    logic               removable;
    logic               flag_now;
    t_res               res_int;
    t_res               res_brd;
    t_res               wr_a;
    logic [1:0]         wr_cnt;
    t_res               q_data;
    logic [FIFO_LW-1:0] q_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= DIM_W'(MAX_WIDTH);
            r_cfg_h <= DIM_W'(MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        priority if (r_cfg_w < DIM_W'(MIN_DIM)) w_use = DIM_W'(MIN_DIM);
        else if (r_cfg_w > DIM_W'(MAX_WIDTH))   w_use = DIM_W'(MAX_WIDTH);
        else                                    w_use = r_cfg_w;
        priority if (r_cfg_h < DIM_W'(MIN_DIM)) h_use = DIM_W'(MIN_DIM);
        else if (r_cfg_h > DIM_W'(MAX_HEIGHT))  h_use = DIM_W'(MAX_HEIGHT);
        else                                    h_use = r_cfg_h;
    end

    // worst case: item in stage 1 and the new one each push two results
    assign s_axis_tready = (q_level <= FIFO_LW'(FIFO_DEPTH - 4));
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---- stage 0: position bookkeeping, line store read ----
    always_comb begin
        col_x   = DIM_W'(r_col);
        row_x   = DIM_W'(r_row);
        col_inc = col_x + DIM_W'(1);
        row_inc = row_x + DIM_W'(1);

        n_s1.valid     = accept;
        n_s1.px        = s_axis_tdata;
        n_s1.col       = r_col;
        n_s1.row       = r_row;
        n_s1.interior  = (row_x >= DIM_W'(2)) && (col_x >= DIM_W'(2))
                         && (row_x <= h_use - DIM_W'(1)) && (col_x <= w_use - DIM_W'(1));
        n_s1.border    = (r_row == '0) || (r_col == '0)
                         || (row_x >= h_use - DIM_W'(1)) || (col_x >= w_use - DIM_W'(1));
        n_s1.last      = (row_inc >= h_use) && (col_inc >= w_use);
        n_s1.frame_end = 1'b0;

        n_col = COORD_W'(col_inc);
        n_row = r_row;
        if (col_inc >= w_use) begin
            n_col = '0;
            n_row = ROW_W'(row_inc);
            if (row_inc >= h_use) begin
                n_row          = '0;
                n_s1.frame_end = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1  <= '0;
        end else begin
            r_s1 <= n_s1;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // consecutive items never share a column, so the write-back of stage 1
    // and the read of stage 0 never hit the same entry in one cycle
    btp_line_store u_line (
        .i_clk     (i_clk),
        .i_rd_addr (LINE_AW'(r_col)),
        .i_wr_en   (r_s1.valid),
        .i_wr_addr (LINE_AW'(r_s1.col)),
        .i_wr_mid  (r_s1.px),
        .i_wr_top  (mem_mid),
        .o_mid     (mem_mid),
        .o_top     (mem_top)
    );

    // ---- stage 1: window shift, decision, push results ----
    btp_window u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (r_s1.valid),
        .i_top       (mem_top),
        .i_mid       (mem_mid),
        .i_px        (r_s1.px),
        .o_center    (center),
        .o_removable (removable)
    );

    always_comb begin
        flag_now = r_flag | (r_s1.interior & removable);

        res_int.pixel   = removable ? PIX_ZERO : center;
        res_int.col     = r_s1.col - COORD_W'(1);
        res_int.row     = r_s1.row - ROW_W'(1);
        res_int.last    = 1'b0;
        res_int.changed = flag_now;

        res_brd.pixel   = r_s1.px;
        res_brd.col     = r_s1.col;
        res_brd.row     = r_s1.row;
        res_brd.last    = r_s1.last;
        res_brd.changed = flag_now;

        // interior decision goes out ahead of the border pixel
        wr_a   = r_s1.interior ? res_int : res_brd;
        wr_cnt = r_s1.valid ? (2'(r_s1.interior) + 2'(r_s1.border)) : 2'd0;

        n_flag = r_flag;
        if (r_s1.valid)
            n_flag = r_s1.frame_end ? 1'b0 : flag_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_flag <= 1'b0;
        else
            r_flag <= n_flag;
    end

    btp_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_cnt (wr_cnt),
        .i_wr_a   (wr_a),
        .i_wr_b   (res_brd),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (q_data),
        .o_level  (q_level)
    );

    assign m_axis_tdata = TDATA_W'({q_data.row, q_data.col, q_data.pixel});
    assign m_axis_tlast = q_data.last;
    assign m_axis_tuser = q_data.changed;

    // ---- checks ----
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FIFO_LW + 1)'(q_level) + (r_s1.valid ? (FIFO_LW + 1)'(2) : '0)
            <= (FIFO_LW + 1)'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_accept_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1.valid)
        else $error("accepted item lost before stage 1");

    a_flag_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && r_s1.frame_end) |=> !r_flag)
        else $error("removed flag not cleared at frame end");

endmodule

/* verif/binary_thinning_pass_3x3_tb.sv */
module binary_thinning_pass_3x3_tb
    import btp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int DONT_CARE     = -1;

    // hit-or-miss templates: 1 wants 255, 0 wants 0, DONT_CARE matches anything
    localparam int THIN_TMPL [2][3][3] = '{
        '{'{0, 0, 0}, '{DONT_CARE, 1, DONT_CARE}, '{1, 1, 1}},
        '{'{DONT_CARE, 0, 0}, '{1, 1, 0}, '{DONT_CARE, 1, DONT_CARE}}
    };

    // three 3x3 frames: template A match, template B match with odd don't-cares,
    // and a nonzero center that is not 255 inside a ring of 255 with one corner at 85
    localparam logic [PIX_W-1:0] EDGE_FRAMES [27] = '{
        8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255,
        8'd128, 8'd0,   8'd0,   8'd255, 8'd255, 8'd0,   8'd1,   8'd255, 8'd254,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd170, 8'd255, 8'd255, 8'd255, 8'd85
    };

    class thin_scoreboard;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        logic [PIX_W-1:0] line_up1 [MAX_WIDTH];
        logic [PIX_W-1:0] line_up2 [MAX_WIDTH];
        logic [PIX_W-1:0] win [3][3];
        int               col_cnt;
        int               row_cnt;
        bit               removed;
        t_res             thinned_q [$];
        int               fails;

        function new();
            width_reg  = DIM_W'(MAX_WIDTH);
            height_reg = DIM_W'(MAX_HEIGHT);
            foreach (line_up1[i]) begin
                line_up1[i] = PIX_ZERO;
                line_up2[i] = PIX_ZERO;
            end
            foreach (win[y, x]) win[y][x] = PIX_ZERO;
            col_cnt = 0;
            row_cnt = 0;
            removed = 1'b0;
            fails   = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [DIM_W-1:0] v);
            if (idx == CFG_IMAGE_WIDTH) width_reg = v;
            else height_reg = v;
        endfunction

        function int clamp_dim(logic [DIM_W-1:0] v, int hi);
            if (int'(v) < MIN_DIM) return MIN_DIM;
            if (int'(v) > hi) return hi;
            return int'(v);
        endfunction

        function int dim(t_cfg_idx idx);
            if (idx == CFG_IMAGE_WIDTH) return clamp_dim(width_reg, MAX_WIDTH);
            return clamp_dim(height_reg, MAX_HEIGHT);
        endfunction

        function int tmpl_at(int t, int rot, int y, int x);
            case (rot)
                1: return THIN_TMPL[t][x][2-y];
                2: return THIN_TMPL[t][2-y][2-x];
                3: return THIN_TMPL[t][2-x][y];
                default: return THIN_TMPL[t][y][x];
            endcase
        endfunction

        function bit tmpl_hit(int t, int rot);
            int e;
            for (int y = 0; y < 3; y++) begin
                for (int x = 0; x < 3; x++) begin
                    e = tmpl_at(t, rot, y, x);
                    if (e == DONT_CARE) continue;
                    if (win[y][x] != ((e == 1) ? PIX_ONE : PIX_ZERO)) return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function bit thinnable();
            int ones;
            ones = 0;
            if (win[1][1] == PIX_ZERO) return 1'b0;
            foreach (win[y, x]) if (win[y][x] == PIX_ONE) ones++;
            if (ones < 3) return 1'b0;
            for (int rot = 0; rot < 4; rot++)
                for (int t = 0; t < 2; t++)
                    if (tmpl_hit(t, rot)) return 1'b1;
            return 1'b0;
        endfunction

        // advance the window by one accepted item and queue what it completes
        function void pixel_taken(logic [PIX_W-1:0] px);
            int               w;
            int               h;
            int               c;
            int               r;
            int               ci;
            logic [PIX_W-1:0] above2;
            logic [PIX_W-1:0] above1;
            bit               frame_end;
            t_res             res;
            w  = dim(CFG_IMAGE_WIDTH);
            h  = dim(CFG_IMAGE_HEIGHT);
            c  = col_cnt;
            r  = row_cnt;
            ci = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
            above2    = line_up2[ci];
            above1    = line_up1[ci];
            frame_end = (r + 1 >= h) && (c + 1 >= w);
            line_up2[ci] = above1;
            line_up1[ci] = px;
            for (int y = 0; y < 3; y++) begin
                win[y][0] = win[y][1];
                win[y][1] = win[y][2];
            end
            win[0][2] = above2;
            win[1][2] = above1;
            win[2][2] = px;

            if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1) begin
                res.pixel = win[1][1];
                if (thinnable()) begin
                    res.pixel = PIX_ZERO;
                    removed   = 1'b1;
                end
                res.col     = COORD_W'(c - 1);
                res.row     = ROW_W'(r - 1);
                res.last    = 1'b0;
                res.changed = removed;
                thinned_q.push_back(res);
            end
            if (r == 0 || c == 0 || r >= h - 1 || c >= w - 1) begin
                res.pixel   = px;
                res.col     = COORD_W'(c);
                res.row     = ROW_W'(r);
                res.last    = frame_end;
                res.changed = removed;
                thinned_q.push_back(res);
            end

            col_cnt = c + 1;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt = r + 1;
                if (row_cnt >= h) begin
                    row_cnt = 0;
                    removed = 1'b0;
                end
            end
        endfunction

        function void check_thinned(t_res got);
            t_res exp;
            if (thinned_q.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result: pix %0d col %0d row %0d last %0d chg %0d",
                             got.pixel, got.col, got.row, got.last, got.changed);
                return;
            end
            exp = thinned_q.pop_front();
            if (got.pixel !== exp.pixel || got.col !== exp.col || got.row !== exp.row ||
                got.last !== exp.last || got.changed !== exp.changed) begin
                fails++;
                if (fails <= 10) begin
                    $display("mismatch: exp pix %0d col %0d row %0d last %0d chg %0d",
                             exp.pixel, exp.col, exp.row, exp.last, exp.changed);
                    $display("          got pix %0d col %0d row %0d last %0d chg %0d",
                             got.pixel, got.col, got.row, got.last, got.changed);
                end
            end
        endfunction

        function int pending();
            return thinned_q.size();
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [PIX_W-1:0]   s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;
    logic               m_axis_tuser;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index   = CFG_IMAGE_WIDTH;
    logic [DIM_W-1:0]   i_cfg_data    = '0;

    thin_scoreboard sb;
    t_res           seen;
    int             pixels_sent = 0;
    int             sink_hold   = 0;
    int unsigned    cycles      = 0;
    bit             hold_req    = 1'b0;
    bit             tx_idle     = 1'b1;
    bit             rx_idle     = 1'b1;

    binary_thinning_pass_3x3 uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("binary_thinning_pass_3x3_tb: done, errors");
            $finish;
        end
    end

    function automatic int stall_len();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    function automatic int pick_gap();
        if (!tx_idle) return 0;
        if ($urandom_range(0, 99) < 55) return 0;
        return stall_len();
    endfunction

    // result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            seen.pixel   = m_axis_tdata[PIX_W-1:0];
            seen.col     = m_axis_tdata[PIX_W +: COORD_W];
            seen.row     = m_axis_tdata[PIX_W+COORD_W +: ROW_W];
            seen.last    = m_axis_tlast;
            seen.changed = m_axis_tuser;
            sb.check_thinned(seen);
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            sink_hold = HOLD_CYCLES;
        end else if (sink_hold == 0 && rx_idle && $urandom_range(0, 99) < 20) begin
            sink_hold = stall_len();
        end
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [PIX_W-1:0] make_pixel(int dens, bit noisy);
        if (noisy && $urandom_range(0, 3) == 0) return PIX_W'($urandom_range(0, 255));
        return ($urandom_range(0, 99) < dens) ? PIX_ONE : PIX_ZERO;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return DIM_W'($urandom_range(0, 2));
        if (r == 1) return DIM_W'($urandom_range(17, 40));
        return DIM_W'($urandom_range(3, 16));
    endfunction

    // valid stays high across back-to-back items; lowered only when a gap follows
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        s_axis_tdata  <= px;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.pixel_taken(px);
        pixels_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_image(input int n, input int dens, input bit noisy);
        repeat (n) send_pixel(make_pixel(dens, noisy));
    endtask

    task automatic finish_frame(input int dens, input bit noisy);
        while (sb.col_cnt != 0 || sb.row_cnt != 0) send_pixel(make_pixel(dens, noisy));
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= w_raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_IMAGE_WIDTH, w_raw);
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= h_raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_IMAGE_HEIGHT, h_raw);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle(input int extra);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int w;
        int h;
        int n;
        int dens;
        int rand_base;
        bit noisy;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest image, both dims below range
        set_dims(DIM_W'(0), DIM_W'(2));
        for (int i = 0; i < 27; i++) send_pixel(EDGE_FRAMES[i]);
        settle(SETTLE_CYCLES);

        // widest row, width above range; frame cut short by shrinking width in row 1
        set_dims(DIM_W'(2047), DIM_W'(3));
        send_image(MAX_WIDTH + 4, 60, 1'b1);
        settle(SETTLE_CYCLES);
        set_dims(DIM_W'(3), DIM_W'(3));
        finish_frame(60, 1'b1);
        settle(SETTLE_CYCLES);

        // tallest image, cut short by shrinking height once rows are past it
        set_dims(DIM_W'(3), DIM_W'(1025));
        send_image(40 * 3, 70, 1'b0);
        settle(SETTLE_CYCLES);
        set_dims(DIM_W'(3), DIM_W'(3));
        finish_frame(70, 1'b0);
        settle(SETTLE_CYCLES);

        // sink holds off while the source keeps pushing: input must back up
        set_dims(DIM_W'(12), DIM_W'(10));
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        send_image(120, 65, 1'b0);
        settle(SETTLE_CYCLES);

        rand_base = pixels_sent;
        while (pixels_sent < rand_base + RANDOM_ITEMS) begin
            tx_idle = ($urandom_range(0, 4) != 0);
            rx_idle = ($urandom_range(0, 4) != 0);
            dens    = $urandom_range(25, 90);
            noisy   = ($urandom_range(0, 3) == 0);
            set_dims(pick_dim(), pick_dim());
            w = sb.dim(CFG_IMAGE_WIDTH);
            h = sb.dim(CFG_IMAGE_HEIGHT);
            n = w * h;
            if ($urandom_range(0, 3) == 0) begin
                // mid-frame change: width may only shrink so no stale line data is read
                send_image($urandom_range(1, n - 1), dens, noisy);
                settle(SETTLE_CYCLES);
                set_dims(DIM_W'($urandom_range(0, w)), DIM_W'($urandom_range(0, 14)));
                finish_frame(dens, noisy);
            end else begin
                send_image((n > 150) ? n : n * $urandom_range(1, 2), dens, noisy);
            end
            settle(SETTLE_CYCLES);
        end

        settle(END_CYCLES);
        if (sb.fails == 0)
            $display("binary_thinning_pass_3x3_tb: done, clean");
        else
            $display("binary_thinning_pass_3x3_tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
sv/btp_pkg.sv
sv/btp_line_store.sv
sv/btp_window.sv
sv/btp_out_fifo.sv
sv/binary_thinning_pass_3x3.sv
verif/binary_thinning_pass_3x3_tb.sv
